[rtl/core/plh_pkg.sv]
// Shared types and fixed-point constants for the HSV palette core.
package plh_pkg;

  // Register indexes of the configuration port
  typedef enum logic [1:0] {
    CFG_HUE_BASE   = 2'd0,
    CFG_HUE_SPAN   = 2'd1,
    CFG_SATURATION = 2'd2,
    CFG_BRIGHTNESS = 2'd3
  } cfg_idx_t;

  // Hue in 1/128 degree
  localparam logic [17:0] HUE_FULL   = 18'd46080;  // 360 deg
  localparam logic [15:0] HUE_SECTOR = 16'd7680;   // 60 deg

  // Q0.16 one
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // HUE_SECTOR * 2^16, the channel term for x = 0
  localparam logic [29:0] TERM_FULL = 30'd503316480;

  // floor(m / 15) == (m * 2185) >> 15 for m < 4681
  localparam logic [11:0] RECIP_15    = 12'd2185;
  localparam int          RECIP_SHIFT = 15;

  // Per-beat side info that bypasses the HSV math
  typedef struct packed {
    logic       neg;   // level negative: black
    logic [7:0] gray;  // level * 255, saturated
  } plh_meta_t;

endpackage

[rtl/core/plh_hue.sv]
// Hue pipeline: level * span, modulo 360 degrees, sector and fraction split.
module plh_hue (
  input  logic        clk,
  input  logic [2:0]  stage_en,
  input  logic [16:0] level,
  input  logic [15:0] hue_base,
  input  logic [15:0] hue_span,
  output logic [2:0]  sector,
  output logic [12:0] frac
);

  logic [32:0] prod_r;
  logic [15:0] hue_r;
  logic [2:0]  sector_r;
  logic [12:0] frac_r;

  logic [17:0] hsum;
  logic [17:0] hue_nxt;
  logic [2:0]  sector_nxt;
  logic [15:0] base;

  // stage 0: level * span
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      prod_r <= 33'(level) * 33'(hue_span);
    end
  end

  // stage 1: add base, reduce modulo 360 deg (sum stays below 5 turns)
  always_comb begin
    hsum = 18'(hue_base) + 18'(prod_r[32:16]);
    if (hsum >= 18'(4 * plh_pkg::HUE_FULL)) begin
      hue_nxt = hsum - 18'(4 * plh_pkg::HUE_FULL);
    end else if (hsum >= 18'(3 * plh_pkg::HUE_FULL)) begin
      hue_nxt = hsum - 18'(3 * plh_pkg::HUE_FULL);
    end else if (hsum >= 18'(2 * plh_pkg::HUE_FULL)) begin
      hue_nxt = hsum - 18'(2 * plh_pkg::HUE_FULL);
    end else if (hsum >= plh_pkg::HUE_FULL) begin
      hue_nxt = hsum - plh_pkg::HUE_FULL;
    end else begin
      hue_nxt = hsum;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      hue_r <= hue_nxt[15:0];
    end
  end

  // stage 2: sector and offset within it
  always_comb begin
    if (hue_r >= 16'(5 * plh_pkg::HUE_SECTOR)) begin
      sector_nxt = 3'd5;
      base       = 16'(5 * plh_pkg::HUE_SECTOR);
    end else if (hue_r >= 16'(4 * plh_pkg::HUE_SECTOR)) begin
      sector_nxt = 3'd4;
      base       = 16'(4 * plh_pkg::HUE_SECTOR);
    end else if (hue_r >= 16'(3 * plh_pkg::HUE_SECTOR)) begin
      sector_nxt = 3'd3;
      base       = 16'(3 * plh_pkg::HUE_SECTOR);
    end else if (hue_r >= 16'(2 * plh_pkg::HUE_SECTOR)) begin
      sector_nxt = 3'd2;
      base       = 16'(2 * plh_pkg::HUE_SECTOR);
    end else if (hue_r >= plh_pkg::HUE_SECTOR) begin
      sector_nxt = 3'd1;
      base       = plh_pkg::HUE_SECTOR;
    end else begin
      sector_nxt = 3'd0;
      base       = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      sector_r <= sector_nxt;
      frac_r   <= 13'(hue_r - base);
    end
  end

  assign sector = sector_r;
  assign frac   = frac_r;

endmodule

[rtl/core/plh_term.sv]
// One channel value: floor(255 * v * (1 - x*s/7680)), three register stages.
module plh_term (
  input  logic        clk,
  input  logic [2:0]  stage_en,
  input  logic [12:0] x,      // 0..7680, fraction weight of s
  input  logic [16:0] sat,    // clamped Q0.16
  input  logic [16:0] bri,    // clamped Q0.16
  output logic [7:0]  chan
);

  logic [28:0] term_r;
  logic [45:0] vt_r;
  logic [11:0] m_r;

  logic [29:0] xs;
  logic [53:0] n255;
  logic [23:0] q;
  logic [8:0]  qs;

  // stage 3: term = 7680*2^16 - x*s
  assign xs = 30'(x) * 30'(sat);

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      term_r <= 29'(plh_pkg::TERM_FULL - xs);
    end
  end

  // stage 4: v * term
  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      vt_r <= 46'(bri) * 46'(term_r);
    end
  end

  // stage 5: *255 then drop the 2^41 part of the 15*2^41 divisor
  assign n255 = (54'(vt_r) << 8) - 54'(vt_r);

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      m_r <= n255[52:41];
    end
  end

  // divide by 15 through the reciprocal
  assign q    = 24'(m_r) * 24'(plh_pkg::RECIP_15);
  assign qs   = q[23:plh_pkg::RECIP_SHIFT];
  assign chan = (qs > 9'd255) ? 8'hFF : qs[7:0];

endmodule

[rtl/core/palette_hsv_to_rgb_core.sv]
// Top level of the HSV palette core: config registers, pipeline control, channel select.
//
// Maps one signed Q2.16 escape level per beat to an 8-bit red/green/blue colour.
// The hue is hue_base + level*hue_span (1/128 degree) modulo 360 degrees,
// then split into 60-degree sectors; saturation and brightness come from
// config. Negative levels give black, zero saturation gives gray (level*255,
// saturated). A beat moves through a seven-stage pipeline (three hue stages,
// three channel-math stages, one output stage) and its colour is held in the
// output register until taken; throughput is one beat per clock while
// out_stall is low. Every stage advances independently, so bubbles close up
// and, while a finished colour waits on out_stall, new beats are taken as long
// as an earlier stage is empty. Config writes must only happen while the
// pipeline is empty.
module palette_hsv_to_rgb_core (
  input  logic        clk,
  input  logic        rst_n,
  // config write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [17:0] in_escape_level,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue
);

  localparam int NSTG = 7;

  // ---------------- configuration registers ----------------
  logic [15:0] hue_base_r;
  logic [15:0] hue_span_r;
  logic [16:0] sat_r;
  logic [16:0] bri_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_base_r <= 16'd0;
      hue_span_r <= 16'd46080;
      sat_r      <= plh_pkg::ONE_Q16;
      bri_r      <= plh_pkg::ONE_Q16;
    end else if (cfg_we) begin
      case (cfg_index)
        plh_pkg::CFG_HUE_BASE:   hue_base_r <= cfg_wdata[15:0];
        plh_pkg::CFG_HUE_SPAN:   hue_span_r <= cfg_wdata[15:0];
        plh_pkg::CFG_SATURATION: sat_r      <= cfg_wdata;
        plh_pkg::CFG_BRIGHTNESS: bri_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // values above 1.0 act as 1.0
  logic [16:0] sat_cl;
  logic [16:0] bri_cl;
  assign sat_cl = (sat_r > plh_pkg::ONE_Q16) ? plh_pkg::ONE_Q16 : sat_r;
  assign bri_cl = (bri_r > plh_pkg::ONE_Q16) ? plh_pkg::ONE_Q16 : bri_r;

  // ---------------- pipeline control ----------------
  // A stage loads when it is empty or the stage after it moves.
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] rdy;

  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NSTG-1];

  // ---------------- stage 0 side path: black / gray ----------------
  logic [24:0] gray_prod;
  logic [8:0]  gray_raw;
  plh_pkg::plh_meta_t meta_nxt;
  plh_pkg::plh_meta_t meta_r [NSTG-1];

  assign gray_prod = (25'(in_escape_level[16:0]) << 8) - 25'(in_escape_level[16:0]);
  assign gray_raw  = gray_prod[24:16];
  assign meta_nxt  = {in_escape_level[17], (gray_raw > 9'd255) ? 8'hFF : gray_raw[7:0]};

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      meta_r[0] <= meta_nxt;
    end
    for (int k = 1; k < NSTG - 1; k++) begin
      if (rdy[k]) begin
        meta_r[k] <= meta_r[k-1];
      end
    end
  end

  // ---------------- hue: stages 0..2 ----------------
  logic [2:0]  sector2;
  logic [12:0] frac2;

  plh_hue u_hue (
    .clk      (clk),
    .stage_en (rdy[2:0]),
    .level    (in_escape_level[16:0]),
    .hue_base (hue_base_r),
    .hue_span (hue_span_r),
    .sector   (sector2),
    .frac     (frac2)
  );

  // sector rides along with the channel math
  logic [2:0] sec_r [3:5];

  always_ff @(posedge clk) begin
    if (rdy[3]) sec_r[3] <= sector2;
    if (rdy[4]) sec_r[4] <= sec_r[3];
    if (rdy[5]) sec_r[5] <= sec_r[4];
  end

  // ---------------- channel terms: stages 3..5 ----------------
  // x weights: v -> 0, min -> 1, dec -> f, inc -> 1-f (in 1/7680)
  logic [12:0] x_inc;
  logic [7:0]  c_v;
  logic [7:0]  c_min;
  logic [7:0]  c_dec;
  logic [7:0]  c_inc;

  assign x_inc = 13'(plh_pkg::HUE_SECTOR - 16'(frac2));

  plh_term u_term_v (
    .clk (clk), .stage_en (rdy[5:3]), .x (13'd0),
    .sat (sat_cl), .bri (bri_cl), .chan (c_v)
  );

  plh_term u_term_min (
    .clk (clk), .stage_en (rdy[5:3]), .x (13'(plh_pkg::HUE_SECTOR)),
    .sat (sat_cl), .bri (bri_cl), .chan (c_min)
  );

  plh_term u_term_dec (
    .clk (clk), .stage_en (rdy[5:3]), .x (frac2),
    .sat (sat_cl), .bri (bri_cl), .chan (c_dec)
  );

  plh_term u_term_inc (
    .clk (clk), .stage_en (rdy[5:3]), .x (x_inc),
    .sat (sat_cl), .bri (bri_cl), .chan (c_inc)
  );

  // ---------------- stage 6: sector table, overrides, output register ----------------
  logic [7:0] red_nxt;
  logic [7:0] green_nxt;
  logic [7:0] blue_nxt;
  logic [7:0] out_red_r;
  logic [7:0] out_green_r;
  logic [7:0] out_blue_r;

  always_comb begin
    case (sec_r[5])
      3'd0: begin red_nxt = c_v;   green_nxt = c_inc; blue_nxt = c_min; end
      3'd1: begin red_nxt = c_dec; green_nxt = c_v;   blue_nxt = c_min; end
      3'd2: begin red_nxt = c_min; green_nxt = c_v;   blue_nxt = c_inc; end
      3'd3: begin red_nxt = c_min; green_nxt = c_dec; blue_nxt = c_v;   end
      3'd4: begin red_nxt = c_inc; green_nxt = c_min; blue_nxt = c_v;   end
      default: begin red_nxt = c_v; green_nxt = c_min; blue_nxt = c_dec; end
    endcase
    if (meta_r[5].neg) begin
      red_nxt   = 8'd0;
      green_nxt = 8'd0;
      blue_nxt  = 8'd0;
    end else if (sat_r == 17'd0) begin
      red_nxt   = meta_r[5].gray;
      green_nxt = meta_r[5].gray;
      blue_nxt  = meta_r[5].gray;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NSTG-1]) begin
      out_red_r   <= red_nxt;
      out_green_r <= green_nxt;
      out_blue_r  <= blue_nxt;
    end
  end

  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

  // ---------------- assertions ----------------
  // black never leaks a colour through the select
  a_neg_black: assert property (@(posedge clk) disable iff (!rst_n)
    rdy[NSTG-1] && vld_r[NSTG-2] && meta_r[5].neg
      |=> out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0)
    else $error("negative level did not give black");

  // gray mode drives all channels alike
  a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
    rdy[NSTG-1] && vld_r[NSTG-2] && !meta_r[5].neg && sat_r == 17'd0
      |=> out_red == out_green && out_green == out_blue)
    else $error("gray output channels differ");

  // in color mode one channel is always the full value term
  a_has_v: assert property (@(posedge clk) disable iff (!rst_n)
    rdy[NSTG-1] && vld_r[NSTG-2] && !meta_r[5].neg && sat_r != 17'd0
      |=> out_red == $past(c_v) || out_green == $past(c_v) || out_blue == $past(c_v))
    else $error("no channel carries the value term");

  // the blocked stage before the output register keeps its beat
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NSTG-2] && !rdy[NSTG-2] |=> vld_r[NSTG-2])
    else $error("stalled pipeline stage dropped its beat");

  // sector index stays within the six-entry table
  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NSTG-2] |-> sec_r[5] <= 3'd5)
    else $error("hue sector out of range");

endmodule
